/* design/ftok_pkg.sv */
package ftok_pkg;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COMMENT = 2'd1,
		PH_WORD    = 2'd2,
		PH_STRING  = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_NUMBER  = 2'd0;
	localparam logic [1:0] KIND_HASH    = 2'd1;
	localparam logic [1:0] KIND_STR_BYTE = 2'd2;
	localparam logic [1:0] KIND_STR_END = 2'd3;

	localparam logic [63:0] HASH_SEED   = 64'd757;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam logic [7:0]  CH_TAB      = 8'h09;
	localparam logic [7:0]  CH_CR       = 8'h0D;
	localparam logic [7:0]  CH_OPEN     = 8'h28;
	localparam logic [7:0]  CH_CLOSE    = 8'h29;
	localparam logic [7:0]  CH_QUOTE    = 8'h22;
	localparam logic [7:0]  CH_X        = 8'h78;
	localparam logic [7:0]  CH_0        = 8'h30;
	localparam logic [7:0]  CH_9        = 8'h39;
	localparam logic [7:0]  CH_LA       = 8'h61;
	localparam logic [7:0]  CH_LF       = 8'h66;
	localparam logic [7:0]  CH_UA       = 8'h41;
	localparam logic [7:0]  CH_UZ       = 8'h5A;
	localparam logic [7:0]  CASE_OFFSET = 8'h20;
	localparam logic [31:0] STR_COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] value;
	} result_t;

endpackage

/* design/forth_token_scanner.sv */
// Channel  Handshake              Payload
// input    in_valid / in_ready    char_in[7:0]
// output   out_valid / out_ready  token_kind[1:0], token_value[63:0]
//
// One character can be taken every cycle unless a result waits in a stalled result register.
// A character is held in the input register; its result, if any, enters the result register
// as the character leaves the input register, and out_valid rises when it does.
// While a result waits in the result register with out_ready low, a character held in the
// input register stays there and in_ready is low; arst_n returns the scanner to the
// between-tokens state.
module forth_token_scanner #(
	parameter int WORD_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  token_kind,
	output logic [63:0] token_value
);

	logic              res_valid;
	logic              res_ready;
	ftok_pkg::result_t res;
	ftok_pkg::result_t out_res;

	ftok_scan #(
		.WORD_MAX(WORD_MAX)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res      (res)
	);

	ftok_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign token_kind  = out_res.kind;
	assign token_value = out_res.value;

endmodule

/* design/ftok_scan.sv */
module ftok_scan #(
	parameter int WORD_MAX = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_in,
	input  logic               res_ready,
	output logic               res_valid,
	output ftok_pkg::result_t  res
);

	localparam int LenW = $clog2(WORD_MAX);
	localparam logic [LenW-1:0] CutLen = LenW'(WORD_MAX - 1);
	localparam logic [LenW-1:0] HexPos = LenW'(1);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              advance;

	ftok_pkg::phase_t  phase_q, phase_d;
	logic [LenW-1:0]   len_q, len_d;
	logic [63:0]       hash_q, hash_d;
	logic [63:0]       num_q, num_d;
	logic              sd_q, sd_d;
	logic              hex_q, hex_d;
	logic              end_q, end_d;
	logic [31:0]       str_q, str_d;

	logic              is_space, is_dec, is_hexl, word_cut;
	logic [7:0]        lc;
	logic [7:0]        digit;
	logic [LenW-1:0]   len_b;
	logic [63:0]       hash_b, num_b;
	logic              sd_b, hex_b, end_b;
	logic [63:0]       hash_t, num_t, num10, num16;
	logic              hex_t, end_t;

	// The input register moves on when the result register can take whatever comes out.
	assign advance  = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	assign is_space = (char_s1 == ftok_pkg::CH_SPACE) ||
		(char_s1 >= ftok_pkg::CH_TAB && char_s1 <= ftok_pkg::CH_CR);
	assign lc = (char_s1 >= ftok_pkg::CH_UA && char_s1 <= ftok_pkg::CH_UZ) ?
		char_s1 + ftok_pkg::CASE_OFFSET : char_s1;
	assign is_dec  = (lc >= ftok_pkg::CH_0 && lc <= ftok_pkg::CH_9);
	assign is_hexl = (lc >= ftok_pkg::CH_LA && lc <= ftok_pkg::CH_LF);
	assign digit   = is_dec ? lc - ftok_pkg::CH_0 : lc - ftok_pkg::CH_LA + 8'd10;
	assign word_cut = (len_q >= CutLen);

	// A word character starts from fresh values between tokens and from the state inside a word.
	always_comb begin
		if (phase_q == ftok_pkg::PH_IDLE) begin
			len_b  = '0;
			hash_b = ftok_pkg::HASH_SEED;
			num_b  = '0;
			sd_b   = is_dec;
			hex_b  = 1'b0;
			end_b  = 1'b0;
		end else begin
			len_b  = len_q;
			hash_b = hash_q;
			num_b  = num_q;
			sd_b   = sd_q;
			hex_b  = hex_q;
			end_b  = end_q;
		end
	end

	always_comb begin
		hash_t = (hash_b << 7) + hash_b + {56'd0, lc};
		num10  = (num_b << 3) + (num_b << 1);
		num16  = num_b << 4;
		num_t  = num_b;
		hex_t  = hex_b;
		end_t  = end_b;
		if (sd_b) begin
			if (len_b == HexPos && lc == ftok_pkg::CH_X) begin
				hex_t = 1'b1;
				num_t = '0;
			end else if (!end_b) begin
				if (is_dec) begin
					num_t = (hex_b ? num16 : num10) + {56'd0, digit};
				end else if (hex_b && is_hexl) begin
					num_t = num16 + {56'd0, digit};
				end else begin
					end_t = 1'b1;
				end
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			ftok_pkg::PH_IDLE: begin
				if (is_space) begin
					phase_d = ftok_pkg::PH_IDLE;
				end else if (char_s1 == ftok_pkg::CH_OPEN) begin
					phase_d = ftok_pkg::PH_COMMENT;
				end else if (char_s1 == ftok_pkg::CH_QUOTE) begin
					phase_d = ftok_pkg::PH_STRING;
				end else begin
					phase_d = ftok_pkg::PH_WORD;
				end
			end
			ftok_pkg::PH_COMMENT: begin
				if (char_s1 == ftok_pkg::CH_CLOSE) begin
					phase_d = ftok_pkg::PH_IDLE;
				end
			end
			ftok_pkg::PH_WORD: begin
				if (is_space || word_cut) begin
					phase_d = ftok_pkg::PH_IDLE;
				end
			end
			ftok_pkg::PH_STRING: begin
				if (char_s1 == ftok_pkg::CH_QUOTE) begin
					phase_d = ftok_pkg::PH_IDLE;
				end
			end
			default: phase_d = ftok_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		len_d     = len_q;
		hash_d    = hash_q;
		num_d     = num_q;
		sd_d      = sd_q;
		hex_d     = hex_q;
		end_d     = end_q;
		str_d     = str_q;
		res_valid = 1'b0;
		res.kind  = ftok_pkg::KIND_STR_BYTE;
		res.value = {56'd0, char_s1};
		unique case (phase_q)
			ftok_pkg::PH_IDLE: begin
				if (char_s1 == ftok_pkg::CH_QUOTE) begin
					str_d = '0;
				end else if (!is_space && char_s1 != ftok_pkg::CH_OPEN) begin
					len_d  = len_b + LenW'(1);
					hash_d = hash_t;
					num_d  = num_t;
					sd_d   = sd_b;
					hex_d  = hex_t;
					end_d  = end_t;
				end
			end
			ftok_pkg::PH_COMMENT: begin
				res_valid = 1'b0;
			end
			ftok_pkg::PH_WORD: begin
				if (is_space || word_cut) begin
					res_valid = valid_s1;
					res.kind  = sd_q ? ftok_pkg::KIND_NUMBER : ftok_pkg::KIND_HASH;
					res.value = sd_q ? num_q : hash_q;
					len_d     = '0;
				end else begin
					len_d  = len_q + LenW'(1);
					hash_d = hash_t;
					num_d  = num_t;
					hex_d  = hex_t;
					end_d  = end_t;
				end
			end
			ftok_pkg::PH_STRING: begin
				res_valid = valid_s1;
				if (char_s1 == ftok_pkg::CH_QUOTE) begin
					res.kind  = ftok_pkg::KIND_STR_END;
					res.value = {32'd0, str_q};
				end else if (str_q != ftok_pkg::STR_COUNT_MAX) begin
					str_d = str_q + 32'd1;
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ftok_pkg::PH_IDLE;
			len_q   <= '0;
			hash_q  <= ftok_pkg::HASH_SEED;
			num_q   <= '0;
			sd_q    <= 1'b0;
			hex_q   <= 1'b0;
			end_q   <= 1'b0;
			str_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			hash_q  <= hash_d;
			num_q   <= num_d;
			sd_q    <= sd_d;
			hex_q   <= hex_d;
			end_q   <= end_d;
			str_q   <= str_d;
		end
	end

endmodule

/* design/ftok_outreg.sv */
module ftok_outreg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  ftok_pkg::result_t  res,
	output logic               res_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ftok_pkg::result_t  out_res
);

	logic              out_valid_q;
	ftok_pkg::result_t out_res_q;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

/* bench/tb_forth_token_scanner.sv */
`timescale 1ns / 100ps

function automatic bit is_blank_char(logic [7:0] c);
	return c == ftok_pkg::CH_SPACE || (c >= ftok_pkg::CH_TAB && c <= ftok_pkg::CH_CR);
endfunction

class token_scoreboard #(parameter int WORD_LIMIT = 32);
	ftok_pkg::phase_t  scan_state;
	int unsigned       word_len;
	logic [63:0]       hash_acc;
	logic [63:0]       num_acc;
	bit                digit_lead;
	bit                hex_mode;
	bit                digits_done;
	logic [31:0]       str_len;
	ftok_pkg::result_t expected_tokens[$];
	int unsigned       mismatches;
	int unsigned       kind_seen[4];

	function new();
		scan_state = ftok_pkg::PH_IDLE;
		word_len = 0;
		hash_acc = ftok_pkg::HASH_SEED;
		num_acc = '0;
		digit_lead = 0;
		hex_mode = 0;
		digits_done = 0;
		str_len = '0;
		mismatches = 0;
		foreach (kind_seen[k]) kind_seen[k] = 0;
	endfunction

	function void add_word_char(logic [7:0] c);
		int unsigned pos;
		pos = word_len;
		hash_acc = (hash_acc << 7) + hash_acc + 64'(c);
		if (digit_lead) begin
			if (pos == 1 && c == ftok_pkg::CH_X) begin
				hex_mode = 1;
				num_acc = '0;
			end else if (!digits_done) begin
				if (c >= ftok_pkg::CH_0 && c <= ftok_pkg::CH_9) begin
					num_acc = num_acc * (hex_mode ? 64'd16 : 64'd10) +
						64'(c - ftok_pkg::CH_0);
				end else if (hex_mode && c >= ftok_pkg::CH_LA && c <= ftok_pkg::CH_LF) begin
					num_acc = (num_acc << 4) + 64'(c - ftok_pkg::CH_LA) + 64'd10;
				end else begin
					digits_done = 1;
				end
			end
		end
		word_len = (word_len + 1) & 6'h3F;
	endfunction

	// Called once for every character the scanner accepts.
	function void scan_char(logic [7:0] raw);
		logic [7:0]        lc;
		ftok_pkg::result_t tok;
		lc = (raw >= ftok_pkg::CH_UA && raw <= ftok_pkg::CH_UZ) ?
			raw + ftok_pkg::CASE_OFFSET : raw;
		case (scan_state)
			ftok_pkg::PH_IDLE: begin
				if (is_blank_char(raw)) begin
				end else if (raw == ftok_pkg::CH_OPEN) begin
					scan_state = ftok_pkg::PH_COMMENT;
				end else if (raw == ftok_pkg::CH_QUOTE) begin
					scan_state = ftok_pkg::PH_STRING;
					str_len = '0;
				end else begin
					scan_state = ftok_pkg::PH_WORD;
					word_len = 0;
					hash_acc = ftok_pkg::HASH_SEED;
					num_acc = '0;
					hex_mode = 0;
					digits_done = 0;
					digit_lead = lc >= ftok_pkg::CH_0 && lc <= ftok_pkg::CH_9;
					add_word_char(lc);
				end
			end
			ftok_pkg::PH_COMMENT: begin
				if (raw == ftok_pkg::CH_CLOSE) scan_state = ftok_pkg::PH_IDLE;
			end
			ftok_pkg::PH_WORD: begin
				// The character at the cut closes the word and is lost.
				if (is_blank_char(raw) || word_len >= WORD_LIMIT - 1) begin
					scan_state = ftok_pkg::PH_IDLE;
					tok.kind = digit_lead ? ftok_pkg::KIND_NUMBER : ftok_pkg::KIND_HASH;
					tok.value = digit_lead ? num_acc : hash_acc;
					expected_tokens.push_back(tok);
					word_len = 0;
				end else begin
					add_word_char(lc);
				end
			end
			default: begin
				if (raw == ftok_pkg::CH_QUOTE) begin
					scan_state = ftok_pkg::PH_IDLE;
					tok.kind = ftok_pkg::KIND_STR_END;
					tok.value = 64'(str_len);
				end else begin
					if (str_len != ftok_pkg::STR_COUNT_MAX) str_len++;
					tok.kind = ftok_pkg::KIND_STR_BYTE;
					tok.value = 64'(raw);
				end
				expected_tokens.push_back(tok);
			end
		endcase
	endfunction

	function void check_token(logic [1:0] kind, logic [63:0] value);
		ftok_pkg::result_t tok;
		bit                bad;
		bit                none;
		bad = 0;
		none = 0;
		if (expected_tokens.size() == 0) begin
			bad = 1;
			none = 1;
			tok = '0;
		end else begin
			tok = expected_tokens.pop_front();
			bad = kind !== tok.kind || value !== tok.value;
		end
		kind_seen[kind]++;
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				if (none)
					$display("%0t: token kind %0d value %h, expected nothing",
						$time, kind, value);
				else
					$display("%0t: token kind %0d value %h, expected kind %0d value %h",
						$time, kind, value, tok.kind, tok.value);
			end
		end
	endfunction
endclass

module tb_forth_token_scanner;
	localparam int WORD_MAX = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 90;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_in;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  token_kind;
	logic [63:0] token_value;

	token_scoreboard #(WORD_MAX) sb;

	int unsigned chars_sent;
	int unsigned token_chars;
	int unsigned quiet_cycles;
	bit          calm;
	bit          hold_request;
	bit          hold_done;
	bit          pause_done;
	logic [7:0]  blank_set[6];

	forth_token_scanner #(.WORD_MAX(WORD_MAX)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.token_value(token_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_len();
		if ($urandom_range(0, 99) < 88) return $urandom_range(1, 8);
		return $urandom_range(28, 40);
	endfunction

	function automatic logic [7:0] any_nonblank();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (is_blank_char(c));
		return c;
	endfunction

	function automatic logic [7:0] any_except(logic [7:0] stop);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == stop);
		return c;
	endfunction

	function automatic logic [7:0] letter_or_byte();
		int r;
		r = $urandom_range(0, 25);
		case ($urandom_range(0, 3))
			0: return ftok_pkg::CH_UA + 8'(r);
			1: return ftok_pkg::CH_LA + 8'(r);
			default: return any_nonblank();
		endcase
	endfunction

	// Offer one item and return at the edge where it is taken.
	task automatic send_char(input logic [7:0] c, input bit counted);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (!in_ready);
		sb.scan_char(c);
		chars_sent++;
		if (counted) token_chars++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1);
	endtask

	task automatic send_random_token();
		int         choice;
		int         len;
		string      hex_digits;
		logic [7:0] c;
		hex_digits = "0123456789abcdefABCDEF";
		choice = $urandom_range(0, 99);
		len = pick_len();
		calm = $urandom_range(0, 9) == 0;
		if (choice < 25) begin
			do c = any_nonblank();
			while (c == ftok_pkg::CH_OPEN || c == ftok_pkg::CH_QUOTE ||
				(c >= ftok_pkg::CH_0 && c <= ftok_pkg::CH_9));
			send_char(c, 1'b1);
			for (int i = 1; i < len; i++) send_char(letter_or_byte(), 1'b1);
		end else if (choice < 40) begin
			send_char(ftok_pkg::CH_0 + 8'($urandom_range(0, 9)), 1'b1);
			for (int i = 1; i < len; i++)
				send_char($urandom_range(0, 99) < 85 ?
					ftok_pkg::CH_0 + 8'($urandom_range(0, 9)) : any_nonblank(), 1'b1);
		end else if (choice < 55) begin
			send_char(ftok_pkg::CH_0 + 8'($urandom_range(0, 9)), 1'b1);
			send_char($urandom_range(0, 1) ? ftok_pkg::CH_X :
				ftok_pkg::CH_X - ftok_pkg::CASE_OFFSET, 1'b1);
			for (int i = 2; i < len; i++)
				send_char($urandom_range(0, 99) < 85 ? hex_digits[$urandom_range(0, 21)]
					: any_nonblank(), 1'b1);
		end else if (choice < 75) begin
			// The long receiver hold lands on a string so every byte backs up a result.
			if (!hold_done && chars_sent >= 200) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
				len = 30;
			end else begin
				len = $urandom_range(0, 12);
			end
			send_char(ftok_pkg::CH_QUOTE, 1'b1);
			for (int i = 0; i < len; i++) send_char(any_except(ftok_pkg::CH_QUOTE), 1'b1);
			send_char(ftok_pkg::CH_QUOTE, 1'b1);
		end else if (choice < 85) begin
			send_char(ftok_pkg::CH_OPEN, 1'b0);
			for (int i = 0; i < len % 10; i++)
				send_char(any_except(ftok_pkg::CH_CLOSE), 1'b0);
			send_char(ftok_pkg::CH_CLOSE, 1'b0);
		end else if (choice < 92) begin
			send_char(ftok_pkg::CH_CLOSE, 1'b1);
			for (int i = 1; i < len; i++) send_char(letter_or_byte(), 1'b1);
		end else begin
			repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 1'b1);
		end
		repeat ($urandom_range(1, 3)) send_char(blank_set[$urandom_range(0, 5)], 1'b0);
	endtask

	// Result side: random stalls, plus one long hold asked for by the sender.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_token(token_kind, token_value);
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Stalled for %0d cycles with %0d tokens pending", quiet_cycles,
				sb.expected_tokens.size());
			$display("forth_token_scanner verification failed");
			$finish;
		end
	end

	initial begin
		sb = new();
		blank_set = '{ftok_pkg::CH_SPACE, ftok_pkg::CH_TAB, 8'h0A, 8'h0B, 8'h0C,
			ftok_pkg::CH_CR};
		chars_sent = 0;
		token_chars = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_in = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short hand-picked text: hex with mixed case, bare prefix, decimal with a tail,
		// every blank kind, a comment, a stray close, and a string with both byte extremes.
		send_text("0 0xfF\t9a7\nAz");
		send_char(blank_set[3], 1'b0);
		send_text("0X ( c)");
		send_char(blank_set[4], 1'b0);
		send_text(") \"");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("\"");
		send_char(ftok_pkg::CH_CR, 1'b0);
		send_text("\"\" ");

		while (chars_sent < 550) begin
			if (!pause_done && chars_sent >= 350) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.expected_tokens.size() != 0);
				pause_done = 1'b1;
			end
			send_random_token();
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (sb.expected_tokens.size() != 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d characters (%0d inside tokens) through words, numbers, strings,",
			chars_sent, token_chars);
		$display("comments and noise; tokens seen: %0d numbers, %0d hashes, %0d bytes, %0d ends",
			sb.kind_seen[ftok_pkg::KIND_NUMBER], sb.kind_seen[ftok_pkg::KIND_HASH],
			sb.kind_seen[ftok_pkg::KIND_STR_BYTE], sb.kind_seen[ftok_pkg::KIND_STR_END]);
		if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
			$display("forth_token_scanner verification clean");
		end else begin
			$display("%0d mismatches, %0d tokens never arrived", sb.mismatches,
				sb.expected_tokens.size());
			$display("forth_token_scanner verification failed");
		end
		$finish;
	end
endmodule

/* files.f */
design/ftok_pkg.sv
design/ftok_scan.sv
design/ftok_outreg.sv
design/forth_token_scanner.sv
bench/tb_forth_token_scanner.sv
